@@ src/avlp_pkg.sv @@
// Package for the attribute/value line parser.
// Holds widths, character codes, status codes and the tracker-to-resolver struct.
package avlp_pkg;

    localparam int MaxLineLen = 4096;
    localparam int PosW       = $clog2(MaxLineLen + 1);
    localparam int SpanW      = 13;
    localparam int NumSep     = 3;
    localparam int CfgW       = 1;
    localparam int CfgIdxW    = 3;

    localparam logic [CfgIdxW-1:0] CFG_SKIP_VALUES = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_AUTO_VALUE  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_KEEP_WS     = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_NO_EQUAL    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_NO_TAB      = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_NO_SPACE    = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_LOWER_ATTR  = 3'd6;

    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [2:0] ST_BLANK   = 3'd0;
    localparam logic [2:0] ST_COMMENT = 3'd1;
    localparam logic [2:0] ST_ATTRVAL = 3'd2;
    localparam logic [2:0] ST_BROKEN  = 3'd3;
    localparam logic [2:0] ST_NOATTR  = 3'd4;

    typedef logic [PosW-1:0] t_pos;

    typedef struct packed {
        logic                skip_values;
        logic                auto_value;
        logic                keep_ws;
        logic [NumSep-1:0]   sep_off;
        logic                lower_attr;
    } t_cfg;

    // Snapshot of one finished line
    typedef struct packed {
        t_pos                position;
        t_pos                first_pos;
        t_pos                end_pos;
        logic                text_seen;
        logic                first_hash;
        logic                overflow;
        logic [NumSep-1:0]   sep_found;
        t_pos [NumSep-1:0]   sep_pos;
        t_pos [NumSep-1:0]   aend;
        logic [NumSep-1:0]   vt_seen;
        t_pos [NumSep-1:0]   vt_pos;
    } t_line;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

@@ src/avlp_front.sv @@
// Front end: per-byte trackers for one line.
// Depends on avlp_pkg; emits one line snapshot per closed line.
module avlp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_character,
    input  logic            i_last,
    input  logic            i_empty_line,
    output logic            o_line_valid,
    output avlp_pkg::t_line o_line,
    input  logic            i_line_stall
);
    import avlp_pkg::*;

    t_line r_st, n_st, cur;
    logic  take, sp, closing;

    assign o_stall = i_line_stall;
    assign take    = i_valid && !i_line_stall;
    assign closing = i_last || i_empty_line;
    assign sp      = is_ws(i_character);

    always_comb begin
        logic [7:0] sc [NumSep];
        sc[0] = CH_EQUAL; sc[1] = CH_TAB; sc[2] = CH_SPACE;
        cur = r_st;
        if (!i_empty_line) begin
            if (r_st.position >= t_pos'(MaxLineLen)) begin
                cur.overflow = 1'b1;
            end else begin
                for (int k = 0; k < NumSep; k++) begin
                    if (!sp && r_st.sep_found[k] && !r_st.vt_seen[k]) begin
                        cur.vt_seen[k] = 1'b1;
                        cur.vt_pos[k]  = r_st.position;
                    end
                    if (i_character == sc[k] && !r_st.sep_found[k]
                        && (r_st.text_seen || !sp)) begin
                        cur.sep_found[k] = 1'b1;
                        cur.sep_pos[k]   = r_st.position;
                        cur.aend[k]      = r_st.text_seen ? r_st.end_pos : r_st.position;
                    end
                end
                if (!sp) begin
                    if (!r_st.text_seen) begin
                        cur.text_seen  = 1'b1;
                        cur.first_pos  = r_st.position;
                        cur.first_hash = (i_character == CH_HASH);
                    end
                    cur.end_pos = r_st.position + t_pos'(1);
                end
                cur.position = r_st.position + t_pos'(1);
            end
        end
        n_st = r_st;
        if (take) n_st = closing ? '0 : cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_line_valid = take && closing;
    assign o_line       = cur;
endmodule

@@ src/avlp_queue.sv @@
// Two-entry queue of line snapshots between tracker and resolver.
// Depends on avlp_pkg.
module avlp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  avlp_pkg::t_line i_line,
    output logic            o_stall,
    output logic            o_valid,
    output avlp_pkg::t_line o_line,
    input  logic            i_stall
);
    import avlp_pkg::*;

    t_line      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && !i_stall;
    assign o_line  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_line;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

@@ src/avlp_back.sv @@
// Back end: classify a finished line and compute spans, registered output.
// Depends on avlp_pkg.
module avlp_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  avlp_pkg::t_line              i_line,
    output logic                         o_stall,
    input  avlp_pkg::t_cfg               i_cfg,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_status,
    output logic                         o_error,
    output logic [avlp_pkg::SpanW-1:0]   o_attr_start,
    output logic [avlp_pkg::SpanW-1:0]   o_attr_length,
    output logic [avlp_pkg::SpanW-1:0]   o_value_start,
    output logic [avlp_pkg::SpanW-1:0]   o_value_length,
    output logic                         o_value_is_auto,
    output logic                         o_lowercase_attr,
    output logic                         o_too_long
);
    import avlp_pkg::*;

    logic       r_valid, take;
    logic [2:0] status;
    t_pos       as, al, vs, vl, s, f, r, aend;
    logic       isauto, novals, trim, hit_any;
    logic [1:0] hit;

    assign o_stall = r_valid && i_stall;
    assign take    = i_valid && !o_stall;

    always_comb begin
        novals  = i_cfg.skip_values || (&i_cfg.sep_off);
        trim    = !i_cfg.keep_ws || novals;
        s       = trim ? i_line.end_pos : i_line.position;
        f       = i_line.first_pos;
        status  = ST_BLANK;
        as = '0; al = '0; vs = '0; vl = '0; isauto = 1'b0;
        hit_any = 1'b0; hit = 2'd0;
        for (int k = NumSep - 1; k >= 0; k--) begin
            if (i_line.sep_found[k] && !i_cfg.sep_off[k] && i_line.sep_pos[k] < s) begin
                hit_any = 1'b1; hit = 2'(k);
            end
        end
        aend = i_line.aend[hit];
        if (!i_cfg.keep_ws)
            r = i_line.vt_seen[hit] ? i_line.vt_pos[hit] : s;
        else
            r = i_line.sep_pos[hit] + t_pos'(1);
        if (!i_line.text_seen) begin
            status = ST_BLANK;
        end else if (i_line.first_hash) begin
            status = ST_COMMENT;
        end else if (novals || (!hit_any && i_cfg.auto_value)) begin
            status = ST_ATTRVAL; as = f; al = s - f;
            if (i_cfg.auto_value) begin vl = t_pos'(1); isauto = 1'b1; end
        end else if (!hit_any) begin
            status = ST_BROKEN;
        end else if (aend <= f) begin
            status = ST_NOATTR;
        end else begin
            status = ST_ATTRVAL; as = f; al = aend - f; vs = r; vl = s - r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            o_status         <= status;
            o_error          <= (status == ST_BROKEN) || (status == ST_NOATTR);
            o_attr_start     <= SpanW'(as);
            o_attr_length    <= SpanW'(al);
            o_value_start    <= SpanW'(vs);
            o_value_length   <= SpanW'(vl);
            o_value_is_auto  <= isauto;
            o_lowercase_attr <= (status == ST_ATTRVAL) && i_cfg.lower_attr;
            o_too_long       <= i_line.overflow;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
endmodule

@@ src/attribute_value_line_parser.sv @@
// Top level of the attribute/value line parser.
// Depends on avlp_pkg, avlp_front, avlp_queue and avlp_back.
// Accepts one word (one byte of a line) per cycle unless o_stall is high; the
// per-byte tracker updates its registered state as each byte is taken. A word
// with i_last or i_empty_line closes the line and yields one result word after
// the two-entry queue and the registered resolver stage. Lines of more than
// 4096 bytes are parsed on their first 4096 bytes and flagged with
// o_too_long. Configuration takes effect for lines resolved after the write;
// write only while idle.
module attribute_value_line_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_character,
    input  logic                       i_last,
    input  logic                       i_empty_line,
    input  logic                       i_cfg_we,
    input  logic [avlp_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [avlp_pkg::CfgW-1:0]  i_cfg_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [2:0]                 o_status,
    output logic                       o_error,
    output logic [avlp_pkg::SpanW-1:0] o_attr_start,
    output logic [avlp_pkg::SpanW-1:0] o_attr_length,
    output logic [avlp_pkg::SpanW-1:0] o_value_start,
    output logic [avlp_pkg::SpanW-1:0] o_value_length,
    output logic                       o_value_is_auto,
    output logic                       o_lowercase_attr,
    output logic                       o_too_long
);
    import avlp_pkg::*;

    t_cfg  r_cfg;
    t_line f_line, q_line;
    logic  f_valid, f_stall, q_valid, q_stall;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SKIP_VALUES: r_cfg.skip_values <= i_cfg_data[0];
                CFG_AUTO_VALUE:  r_cfg.auto_value  <= i_cfg_data[0];
                CFG_KEEP_WS:     r_cfg.keep_ws     <= i_cfg_data[0];
                CFG_NO_EQUAL:    r_cfg.sep_off[0]  <= i_cfg_data[0];
                CFG_NO_TAB:      r_cfg.sep_off[1]  <= i_cfg_data[0];
                CFG_NO_SPACE:    r_cfg.sep_off[2]  <= i_cfg_data[0];
                CFG_LOWER_ATTR:  r_cfg.lower_attr  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    avlp_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_character, .i_last, .i_empty_line,
        .o_line_valid(f_valid), .o_line(f_line), .i_line_stall(f_stall)
    );

    avlp_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .i_line(f_line), .o_stall(f_stall),
        .o_valid(q_valid), .o_line(q_line), .i_stall(q_stall)
    );

    avlp_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_line(q_line), .o_stall(q_stall),
        .i_cfg(r_cfg), .o_valid, .i_stall,
        .o_status, .o_error, .o_attr_start, .o_attr_length,
        .o_value_start, .o_value_length, .o_value_is_auto,
        .o_lowercase_attr, .o_too_long
    );
endmodule

@@ dv/attribute_value_line_parser_tb.sv @@
// Self-checking testbench for attribute_value_line_parser.
// Depends on avlp_pkg and the parser RTL; it streams lines, predicts results and compares.
`timescale 1ns / 1ps

module attribute_value_line_parser_tb;
    import avlp_pkg::*;

    localparam int MaxLen    = 4096;
    localparam int WatchdogCycles = 20000;

    typedef struct packed {
        logic [2:0]  status;
        logic        error;
        logic [12:0] attr_start;
        logic [12:0] attr_length;
        logic [12:0] value_start;
        logic [12:0] value_length;
        logic        value_is_auto;
        logic        lowercase_attr;
        logic        too_long;
    } t_result;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       empty;
        logic       has_gold;   // typed-in expectation present
        t_result    gold;
    } t_row;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [7:0]           in_char;
    logic                 in_last;
    logic                 in_empty;
    logic                 cfg_we;
    logic [CfgIdxW-1:0]   cfg_index;
    logic [CfgW-1:0]      cfg_data;
    logic                 out_valid;
    logic                 out_stall;
    logic [2:0]           out_status;
    logic                 out_error;
    logic [SpanW-1:0]     out_attr_start;
    logic [SpanW-1:0]     out_attr_length;
    logic [SpanW-1:0]     out_value_start;
    logic [SpanW-1:0]     out_value_length;
    logic                 out_value_is_auto;
    logic                 out_lowercase_attr;
    logic                 out_too_long;

    attribute_value_line_parser u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_stall          (in_stall),
        .i_character      (in_char),
        .i_last           (in_last),
        .i_empty_line     (in_empty),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_valid          (out_valid),
        .i_stall          (out_stall),
        .o_status         (out_status),
        .o_error          (out_error),
        .o_attr_start     (out_attr_start),
        .o_attr_length    (out_attr_length),
        .o_value_start    (out_value_start),
        .o_value_length   (out_value_length),
        .o_value_is_auto  (out_value_is_auto),
        .o_lowercase_attr (out_lowercase_attr),
        .o_too_long       (out_too_long)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Shadow configuration and per-line tracker state of the predictor
    t_cfg        shadow_cfg;
    int unsigned ln_pos, ln_first, ln_end;
    bit          ln_text, ln_hash, ln_over;
    bit          ln_sep_found [3];
    int unsigned ln_sep_pos [3];
    int unsigned ln_aend [3];
    bit          ln_vt_seen [3];
    int unsigned ln_vt_pos [3];

    t_result     pending_results [$];
    int          error_count;
    int unsigned idle_cycles;
    bit          quiet_mode;     // no idling in the closing part
    bit          hold_off_req;   // ask the receiver for a long stall

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] sep_code(input int k);
        return k == 0 ? CH_EQUAL : (k == 1 ? CH_TAB : CH_SPACE);
    endfunction

    task automatic clear_line_state();
        ln_pos = 0; ln_first = 0; ln_end = 0;
        ln_text = 0; ln_hash = 0; ln_over = 0;
        for (int k = 0; k < 3; k++) begin
            ln_sep_found[k] = 0; ln_sep_pos[k] = 0; ln_aend[k] = 0;
            ln_vt_seen[k] = 0; ln_vt_pos[k] = 0;
        end
    endtask

    task automatic track_byte(input logic [7:0] c);
        bit sp;
        sp = is_space(c);
        if (ln_pos >= MaxLen) begin
            ln_over = 1;
            return;
        end
        if (!sp)
            for (int k = 0; k < 3; k++)
                if (ln_sep_found[k] && !ln_vt_seen[k]) begin
                    ln_vt_seen[k] = 1; ln_vt_pos[k] = ln_pos;
                end
        for (int k = 0; k < 3; k++)
            if (c == sep_code(k) && !ln_sep_found[k] && (ln_text || !sp)) begin
                ln_sep_found[k] = 1;
                ln_sep_pos[k]   = ln_pos;
                ln_aend[k]      = ln_text ? ln_end : ln_pos;
            end
        if (!sp) begin
            if (!ln_text) begin
                ln_text = 1; ln_first = ln_pos; ln_hash = (c == CH_HASH);
            end
            ln_end = ln_pos + 1;
        end
        ln_pos++;
    endtask

    // Classify the finished line under the current shadow configuration
    function automatic t_result classify_line();
        t_result     r;
        bit          novals, trim;
        int unsigned s, f, aend, vstart;
        int          hit;
        r = '0;
        hit = -1;
        novals = shadow_cfg.skip_values || shadow_cfg.sep_off == 3'b111;
        trim = !shadow_cfg.keep_ws || novals;
        s = trim ? ln_end : ln_pos;
        f = ln_first;
        if (!ln_text) begin
            r.status = ST_BLANK;
        end else if (ln_hash) begin
            r.status = ST_COMMENT;
        end else if (novals) begin
            r.status = ST_ATTRVAL; r.attr_start = 13'(f); r.attr_length = 13'(s - f);
            if (shadow_cfg.auto_value) begin
                r.value_length = 13'd1; r.value_is_auto = 1'b1;
            end
        end else begin
            for (int k = 0; k < 3; k++)
                if (hit < 0 && ln_sep_found[k] && !shadow_cfg.sep_off[k] && ln_sep_pos[k] < s)
                    hit = k;
            if (hit < 0) begin
                if (shadow_cfg.auto_value) begin
                    r.status = ST_ATTRVAL; r.attr_start = 13'(f);
                    r.attr_length = 13'(s - f);
                    r.value_length = 13'd1; r.value_is_auto = 1'b1;
                end else begin
                    r.status = ST_BROKEN;
                end
            end else begin
                aend = ln_aend[hit];
                if (!shadow_cfg.keep_ws)
                    vstart = ln_vt_seen[hit] ? ln_vt_pos[hit] : s;
                else
                    vstart = ln_sep_pos[hit] + 1;
                if (aend <= f) begin
                    r.status = ST_NOATTR;
                end else begin
                    r.status = ST_ATTRVAL; r.attr_start = 13'(f);
                    r.attr_length = 13'(aend - f);
                    r.value_start = 13'(vstart); r.value_length = 13'(s - vstart);
                end
            end
        end
        r.error = (r.status == ST_BROKEN || r.status == ST_NOATTR);
        r.lowercase_attr = (r.status == ST_ATTRVAL) ? shadow_cfg.lower_attr : 1'b0;
        r.too_long = ln_over;
        return r;
    endfunction

    // Hand one word to the block; update the predictor once it is taken
    task automatic send_word(input logic [7:0] c, input logic lst, input logic emp,
                             input bit has_gold, input t_result gold);
        t_result r;
        if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        in_last  <= lst;
        in_empty <= emp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (!emp) track_byte(c);
        if (lst || emp) begin
            r = classify_line();
            if (has_gold && r != gold) begin
                $display("%0t: table row disagrees with predictor: table %h, predicted %h",
                         $realtime, gold, r);
                error_count++;
            end
            pending_results.push_back(r);
            clear_line_state();
        end
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_word(txt[i], i == txt.len() - 1, 1'b0, 0, '0);
    endtask

    // Write one register; only called with nothing in flight
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        case (idx)
            CFG_SKIP_VALUES: shadow_cfg.skip_values = v;
            CFG_AUTO_VALUE:  shadow_cfg.auto_value  = v;
            CFG_KEEP_WS:     shadow_cfg.keep_ws     = v;
            CFG_NO_EQUAL:    shadow_cfg.sep_off[0]  = v;
            CFG_NO_TAB:      shadow_cfg.sep_off[1]  = v;
            CFG_NO_SPACE:    shadow_cfg.sep_off[2]  = v;
            CFG_LOWER_ATTR:  shadow_cfg.lower_attr  = v;
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_cfg(input logic [6:0] bits);
        drain();
        write_reg(CFG_SKIP_VALUES, bits[0]);
        write_reg(CFG_AUTO_VALUE,  bits[1]);
        write_reg(CFG_KEEP_WS,     bits[2]);
        write_reg(CFG_NO_EQUAL,    bits[3]);
        write_reg(CFG_NO_TAB,      bits[4]);
        write_reg(CFG_NO_SPACE,    bits[5]);
        write_reg(CFG_LOWER_ATTR,  bits[6]);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0:       return CH_EQUAL;
            1:       return CH_TAB;
            2, 3:    return CH_SPACE;
            4:       return CH_HASH;
            5:       return 8'($urandom_range(10, 13));
            6:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    // Random line: mostly key/sep/value shapes, some pure noise
    task automatic send_random_line();
        int n;
        bit close_empty;
        close_empty = ($urandom_range(0, 9) == 0);
        n = $urandom_range(close_empty ? 0 : 1, 14);
        for (int i = 0; i < n; i++) begin
            logic [7:0] c;
            if ($urandom_range(0, 3) == 0)
                c = pick_char();
            else if (i == n / 2)
                c = sep_code($urandom_range(0, 2));
            else
                c = ($urandom_range(0, 4) == 0) ? CH_SPACE : 8'($urandom_range(8'h21, 8'h7E));
            send_word(c, !close_empty && i == n - 1, 1'b0, 0, '0);
        end
        if (close_empty)
            send_word(pick_char(), 1'($urandom_range(0, 1)), 1'b1, 0, '0);
    endtask

    // Directed table: blank, comment, split, broken, no attribute
    t_row directed_rows [$];

    task automatic build_rows();
        t_row r;
        r = '{8'hFF, 1'b0, 1'b1, 1, '0};            // empty-line word ignores its byte
        directed_rows.push_back(r);
        r = '{CH_SPACE, 1'b1, 1'b0, 1, '0};         // whitespace only: blank
        directed_rows.push_back(r);
        r = '{CH_HASH, 1'b1, 1'b0, 1, '0};
        r.gold.status = ST_COMMENT;
        directed_rows.push_back(r);
        r = '{8'h00, 1'b1, 1'b0, 1, '0};            // lone byte, no separator: broken
        r.gold.status = ST_BROKEN; r.gold.error = 1;
        directed_rows.push_back(r);
        r = '{CH_EQUAL, 1'b1, 1'b0, 1, '0};         // separator with nothing before it
        r.gold.status = ST_NOATTR; r.gold.error = 1;
        directed_rows.push_back(r);
        r = '{8'hFF, 1'b0, 1'b0, 0, '0};            // high byte is text
        directed_rows.push_back(r);
        r = '{CH_EQUAL, 1'b0, 1'b0, 0, '0};
        directed_rows.push_back(r);
        r = '{8'h80, 1'b1, 1'b0, 0, '0};
        directed_rows.push_back(r);
    endtask

    // Receiver: random stalls, one long hold-off on request
    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (60) @(posedge clk);
                out_stall <= 1'b0;
                hold_off_req = 0;
            end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            t_result got, want;
            got = '{out_status, out_error, out_attr_start, out_attr_length,
                    out_value_start, out_value_length, out_value_is_auto,
                    out_lowercase_attr, out_too_long};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $realtime, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got != want) begin
                    $display("%0t: mismatch: expected st=%0d err=%0d as=%0d al=%0d vs=%0d vl=%0d auto=%0d lc=%0d tl=%0d",
                             $realtime, want.status, want.error, want.attr_start,
                             want.attr_length, want.value_start, want.value_length,
                             want.value_is_auto, want.lowercase_attr, want.too_long);
                    $display("%0t:           actual st=%0d err=%0d as=%0d al=%0d vs=%0d vl=%0d auto=%0d lc=%0d tl=%0d",
                             $realtime, got.status, got.error, got.attr_start,
                             got.attr_length, got.value_start, got.value_length,
                             got.value_is_auto, got.lowercase_attr, got.too_long);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no word accepted on either side
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchdogCycles) begin
            $display("attribute_value_line_parser_tb: done, errors");
            $finish;
        end
    end

    initial begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_char     <= '0;
        in_last     <= 1'b0;
        in_empty    <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        shadow_cfg  = '0;
        error_count = 0;
        quiet_mode  = 0;
        hold_off_req = 0;
        clear_line_state();
        build_rows();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].empty,
                      directed_rows[i].has_gold, directed_rows[i].gold);
        send_text("  Key = val ue  ");
        send_text("a\tb c");
        send_text("k   ");
        apply_cfg(7'b1111111);
        send_text(" Key = v ");
        apply_cfg(7'b1000110);
        send_text("Key   ");
        send_text("x =  y  ");
        apply_cfg(7'b0011000);
        send_text("a=b\tc d");

        // Overlong line: parse stops at the maximum length
        apply_cfg(7'b0000000);
        for (int i = 0; i < MaxLen + 3; i++)
            send_word(i == 2 ? CH_EQUAL : 8'h61, i == MaxLen + 2, 1'b0, 0, '0);

        // Hold the output off while lines keep coming, so the block backs up
        hold_off_req = 1;
        for (int i = 0; i < 6; i++) send_text("ab=c");

        for (int phase = 0; phase < 8; phase++) begin
            apply_cfg(7'($urandom_range(0, 127)));
            if (phase == 7) quiet_mode = 1;
            for (int n = 0; n < 8; n++) send_random_line();
        end

        drain();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("attribute_value_line_parser_tb: done, clean");
        else
            $display("attribute_value_line_parser_tb: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
src/avlp_pkg.sv
src/avlp_front.sv
src/avlp_queue.sv
src/avlp_back.sv
src/attribute_value_line_parser.sv
dv/attribute_value_line_parser_tb.sv
